@@ hdl/hkc_pkg.sv @@
// package of the housekeeping adc channel calibrator
// types, state codes, scheme codes, fixed-point constants and channel tables
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package hkc_pkg;

   // fixed-point format and address limits
   localparam int FRAC_BITS          = 16;
   localparam int NUM_BOARDS         = 3;
   localparam int CHANNELS_PER_BOARD = 40;
   localparam int TBL_BOARDS         = 3;
   localparam int TBL_CHANS          = 40;

   // operand widths of the serial units
   localparam int DATA_W = 64;
   localparam int MUL_B_W = 33;
   localparam int DEN_W = 36;

   // register indexes
   localparam logic CSR_DEFAULT_ZERO = 1'b0;
   localparam logic CSR_DEFAULT_FULL = 1'b1;

   // reset values of the default references
   localparam logic [11:0] DEFAULT_ZERO_RST = 12'd2048;
   localparam logic [11:0] DEFAULT_FULL_RST = 12'd4055;

   // supply latch address
   localparam logic [1:0] SUPPLY_BOARD = 2'd1;
   localparam logic [5:0] SUPPLY_CHAN  = 6'd6;

   // scheme codes
   localparam logic [3:0] SCH_PASS       = 4'd0;
   localparam logic [3:0] SCH_LINEAR     = 4'd1;
   localparam logic [3:0] SCH_ACCEL_LO   = 4'd2;
   localparam logic [3:0] SCH_LOW_PRESS  = 4'd5;
   localparam logic [3:0] SCH_ACCEL_HI   = 4'd9;
   localparam logic [3:0] SCH_HIGH_PRESS = 4'd10;

   // fixed-point constants
   localparam logic signed [63:0] FX_ONE   = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] LIN_ICPT = -(64'sd2731500 <<< FRAC_BITS);
   localparam logic signed [63:0] LP_C0    = 64'sd215181 <<< FRAC_BITS;
   localparam logic signed [63:0] LP_C1    = 64'sd400620000;
   localparam logic signed [63:0] LP_C2    = 64'sd276420;
   localparam logic signed [32:0] LIN_SLOPE_STD = 33'sd1000000;
   localparam logic signed [32:0] LP_C3    = 33'sd68046;
   localparam logic signed [32:0] HP_GAIN  = 33'sd4934250;
   localparam logic signed [32:0] MILLI    = 33'sd1000;
   localparam logic signed [35:0] DEN_E4   = 36'sd10000;
   localparam logic signed [35:0] DEN_E10  = 36'sd10000000000;
   localparam logic signed [35:0] DEN_HP   = 36'sd4000000000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_VOLT,
      ST_DISPATCH,
      ST_LIN_MUL,
      ST_LP_SQ,
      ST_LP_SQDIV,
      ST_LP_M1,
      ST_LP_M2,
      ST_LP_PDIV,
      ST_LP_M3,
      ST_HP_MUL,
      ST_AC_DIV,
      ST_AC_M1,
      ST_AC_M2,
      ST_FIN_DIV,
      ST_LATCH
   } state_type;

   typedef struct packed {
      logic signed [31:0] val;
      logic               ovf;
   } sat_type;

   // scheme per channel
   localparam logic [3:0] SCHEME_B0 [TBL_CHANS] = '{
      4'd0,4'd0,4'd1,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,
      4'd0,4'd1,4'd0,4'd0,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,
      4'd0,4'd0,4'd0,4'd0,4'd1,4'd0,4'd0,4'd0,4'd1,4'd0,
      4'd0,4'd0,4'd0,4'd0,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1};
   localparam logic [3:0] SCHEME_B1 [TBL_CHANS] = '{
      4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd3,4'd2,
      4'd4,4'd5,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd0,4'd0,
      4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd6,4'd7,4'd8,
      4'd9,4'd10,4'd0,4'd1,4'd1,4'd0,4'd1,4'd1,4'd0,4'd0};

   // board 1 slopes scaled by 1e4
   localparam logic signed [31:0] SLOPE_B1 [TBL_CHANS] = '{
      32'sd20000, 32'sd10000, 32'sd20000, -32'sd40000, 32'sd40000,
      32'sd20000, 32'sd20000, 32'sd10000, 32'sd10000, 32'sd10000,
      32'sd10000, 32'sd10000, 32'sd10000, 32'sd80000, 32'sd80000,
      32'sd200000, 32'sd200000, 32'sd200000, 32'sd10000, 32'sd10000,
      32'sd8000, 32'sd80000, 32'sd8000, 32'sd8000, 32'sd200000,
      32'sd200000, 32'sd8000, 32'sd10000, 32'sd10000, 32'sd10000,
      32'sd10000, 32'sd10000, 32'sd10000, 32'sd40000, 32'sd40000,
      32'sd10000, 32'sd101377, 32'sd182520, 32'sd10000, 32'sd10000};

   // accelerometer gain numerator, 1000 x gain denominator, offset in thousandths
   localparam logic signed [32:0] ACC_NUM [11] = '{
      33'sd0, 33'sd0, 33'sd444, 33'sd1000, 33'sd1000, 33'sd0,
      33'sd1000, 33'sd1000, 33'sd1000, 33'sd1000, 33'sd0};
   localparam logic signed [35:0] ACC_DENK [11] = '{
      36'sd1000, 36'sd1000, 36'sd10000, 36'sd844000, 36'sd839000, 36'sd1000,
      36'sd843000, 36'sd827000, 36'sd842000, 36'sd830000, 36'sd1000};
   localparam logic signed [63:0] ACC_OFF [11] = '{
      64'sd0, 64'sd0, 64'sd1375, 64'sd2523, 64'sd2512, 64'sd0,
      64'sd2523, 64'sd2523, 64'sd2506, 64'sd2493, 64'sd0};

   // saturate to 32 bits
   function automatic sat_type sat32(input logic signed [63:0] x);
      sat_type r;
      if (x > 64'sd2147483647) begin
         r.val = 32'sh7fffffff;
         r.ovf = 1'b1;
      end else if (x < -64'sd2147483648) begin
         r.val = 32'sh80000000;
         r.ovf = 1'b1;
      end else begin
         r.val = x[31:0];
         r.ovf = 1'b0;
      end
      return r;
   endfunction

   // full scale of the sign of x
   function automatic logic signed [31:0] sign_max(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sd0) r = 32'sh7fffffff;
      else if (x < 64'sd0) r = 32'sh80000000;
      else r = 32'sd0;
      return r;
   endfunction

   // scheme lookup, pass-through outside the tables
   function automatic logic [3:0] scheme_of(input logic [1:0] board, input logic [5:0] chan);
      logic [3:0] r;
      r = SCH_PASS;
      if (chan < 6'(TBL_CHANS)) begin
         unique case (board)
            2'd0: r = SCHEME_B0[chan];
            2'd1: r = SCHEME_B1[chan];
            2'd2: r = SCH_LINEAR;
            default: r = SCH_PASS;
         endcase
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ hdl/hkc_req_if.sv @@
// request channel of the calibrator: valid, ready and one adc channel sample
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface hkc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  board_index;
   logic [5:0]  channel_index;
   logic [15:0] raw_code;
   logic [15:0] zero_ref_code;
   logic        zero_ref_valid;
   logic [15:0] full_ref_code;
   logic        full_ref_valid;

   modport source (output valid, board_index, channel_index, raw_code, zero_ref_code,
                   zero_ref_valid, full_ref_code, full_ref_valid, input ready);
   modport sink (input valid, board_index, channel_index, raw_code, zero_ref_code,
                 zero_ref_valid, full_ref_code, full_ref_valid, output ready);
endinterface
`default_nettype wire

@@ hdl/hkc_rsp_if.sv @@
// result channel of the calibrator: valid, ready and one calibrated channel
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface hkc_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         out_board;
   logic [5:0]         out_channel;
   logic signed [31:0] volts_value;
   logic signed [31:0] physical_value;
   logic               range_error;

   modport source (output valid, out_board, out_channel, volts_value, physical_value,
                   range_error, input ready);
   modport sink (input valid, out_board, out_channel, volts_value, physical_value,
                 range_error, output ready);
endinterface
`default_nettype wire

@@ hdl/hkc_serial_mul.sv @@
// bit-serial signed multiplier, one multiplier bit per cycle, product mod 2^64
// depends on hkc_pkg
`timescale 1ns / 1ps
`default_nettype none
module hkc_serial_mul
   import hkc_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic signed [DATA_W-1:0]   mcand,
   input  wire logic signed [MUL_B_W-1:0]  mplier,
   output logic                            done,
   output logic signed [DATA_W-1:0]        prod
);

   localparam int CNT_W = $clog2(MUL_B_W);

   logic                      run_ff, run_in;
   logic                      done_ff, done_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic signed [DATA_W-1:0]  acc_ff, acc_in;
   logic signed [DATA_W-1:0]  mcand_ff, mcand_in;
   logic signed [MUL_B_W-1:0] mplier_ff, mplier_in;
   logic signed [DATA_W-1:0]  addend;
   logic                      last;

   // one partial product per cycle, sign bit of the multiplier weighs negative
   always_comb begin
      run_in    = run_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      last      = (cnt_ff == CNT_W'(MUL_B_W - 1));
      addend    = mplier_ff[0] ? mcand_ff : '0;
      done_in   = 1'b0;
      if (start) begin
         run_in    = 1'b1;
         cnt_in    = '0;
         acc_in    = '0;
         mcand_in  = mcand;
         mplier_in = mplier;
      end else if (run_ff) begin
         acc_in    = last ? (acc_ff - addend) : (acc_ff + addend);
         mcand_in  = mcand_ff <<< 1;
         mplier_in = mplier_ff >>> 1;
         cnt_in    = cnt_ff + 1'b1;
         if (last) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule
`default_nettype wire

@@ hdl/hkc_serial_div.sv @@
// bit-serial signed divider, round to nearest with ties away from zero
// restoring, one quotient bit per cycle; depends on hkc_pkg
`timescale 1ns / 1ps
`default_nettype none
module hkc_serial_div
   import hkc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic signed [DATA_W-1:0]  num,
   input  wire logic signed [DEN_W-1:0]   den,
   output logic                           done,
   output logic signed [DATA_W-1:0]       quo
);

   localparam int CNT_W = $clog2(DATA_W);

   logic                     run_ff, run_in;
   logic                     done_ff, done_in;
   logic                     neg_ff, neg_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [DATA_W-1:0]        dvd_ff, dvd_in;
   logic [DEN_W-1:0]         rem_ff, rem_in;
   logic [DEN_W-1:0]         ud_ff, ud_in;
   logic [DEN_W-1:0]         den_abs;
   logic signed [DATA_W-1:0] num_adj;
   logic [DATA_W-1:0]        mag;
   logic [DEN_W-1:0]         rem_sh;
   logic                     ge;

   // sign fix-up and half-divisor bias, then shift-subtract
   always_comb begin
      den_abs = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
      num_adj = den[DEN_W-1] ? -num : num;
      mag     = num_adj[DATA_W-1] ? DATA_W'(-num_adj) : DATA_W'(num_adj);
      rem_sh  = {rem_ff[DEN_W-2:0], dvd_ff[DATA_W-1]};
      ge      = (rem_sh >= ud_ff);
      run_in  = run_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      ud_in   = ud_ff;
      done_in = 1'b0;
      if (start) begin
         run_in = 1'b1;
         neg_in = num_adj[DATA_W-1];
         cnt_in = '0;
         dvd_in = mag + DATA_W'(den_abs >> 1);
         rem_in = '0;
         ud_in  = den_abs;
      end else if (run_ff) begin
         rem_in = ge ? (rem_sh - ud_ff) : rem_sh;
         dvd_in = {dvd_ff[DATA_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DATA_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      ud_ff  <= ud_in;
   end

   assign done = done_ff;
   assign quo  = neg_ff ? -$signed(dvd_ff) : $signed(dvd_ff);

endmodule
`default_nettype wire

@@ hdl/hk_adc_channel_calibrator.sv @@
// top level of the housekeeping adc channel calibrator: sequencer and datapath
// depends on hkc_pkg, hkc_req_if, hkc_rsp_if, hkc_serial_mul, hkc_serial_div
//
//   channel   direction   handshake      payload
//   req_chan  in          valid/ready    board, channel, raw, zero ref, full ref
//   rsp_chan  out         valid/ready    board, channel, volts, physical, range error
//   csr_*     in          write enable   register index, 12-bit data
//
// one request at a time: a request is taken only in idle, after the last result has gone on
// to the output register; a zero span skips the voltage division and, with no supply latched,
// the accelerometer ratio division is skipped; each serial division takes 64 steps and each
// serial multiply 33 steps
// a finished result waits in the output register while the next request is taken
// synchronous reset clears control state and the supply latch and loads the default references
`timescale 1ns / 1ps
`default_nettype none
module hk_adc_channel_calibrator
   import hkc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   hkc_req_if.sink          req_chan,
   hkc_rsp_if.source        rsp_chan,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [11:0] csr_wdata
);

   state_type state_ff, state_in;

   logic                     op_busy_ff, op_busy_in;
   logic [1:0]               board_ff, board_in;
   logic [5:0]               chan_ff, chan_in;
   logic signed [12:0]       diff_ff, diff_in;
   logic signed [12:0]       span_ff, span_in;
   logic                     intbl_ff, intbl_in;
   logic [3:0]               sch_ff, sch_in;
   logic                     flag_ff, flag_in;
   logic signed [31:0]       volts_ff, volts_in;
   logic signed [31:0]       aux_ff, aux_in;
   logic signed [31:0]       phys_ff, phys_in;
   logic signed [63:0]       x_ff, x_in;
   logic signed [DEN_W-1:0]  fden_ff, fden_in;
   logic signed [31:0]       supply_ff, supply_in;
   logic [11:0]              dzero_ff, dfull_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               o_board_ff, o_board_in;
   logic [5:0]               o_chan_ff, o_chan_in;
   logic signed [31:0]       o_volts_ff, o_volts_in;
   logic signed [31:0]       o_phys_ff, o_phys_in;
   logic                     o_err_ff, o_err_in;

   logic                     mul_start, mul_done;
   logic signed [63:0]       mul_a, mul_prod;
   logic signed [32:0]       mul_b;
   logic                     div_start, div_done;
   logic signed [63:0]       div_num, div_quo;
   logic signed [DEN_W-1:0]  div_den;

   logic                     accept;
   logic                     out_free;
   logic [11:0]              zero_sel, full_sel;
   logic signed [63:0]       v64, d64, s64;
   logic signed [35:0]       span36;
   sat_type                  sat_div, sat_latch;
   logic                     latch_hit;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // shared serial units
   hkc_serial_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .mcand  (mul_a),
      .mplier (mul_b),
      .done   (mul_done),
      .prod   (mul_prod)
   );

   hkc_serial_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (accept) state_in = ST_VOLT;
         ST_VOLT:     if (span_ff == 13'sd0 || div_done) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            priority if (!intbl_ff) state_in = ST_LATCH;
            else if (sch_ff == SCH_LINEAR) state_in = ST_LIN_MUL;
            else if (sch_ff == SCH_LOW_PRESS) state_in = ST_LP_SQ;
            else if (sch_ff == SCH_HIGH_PRESS) state_in = ST_HP_MUL;
            else if (sch_ff >= SCH_ACCEL_LO && sch_ff <= SCH_ACCEL_HI) state_in = ST_AC_DIV;
            else state_in = ST_LATCH;
         end
         ST_LIN_MUL:  if (mul_done) state_in = ST_FIN_DIV;
         ST_LP_SQ:    if (mul_done) state_in = ST_LP_SQDIV;
         ST_LP_SQDIV: if (div_done) state_in = ST_LP_M1;
         ST_LP_M1:    if (mul_done) state_in = ST_LP_M2;
         ST_LP_M2:    if (mul_done) state_in = ST_LP_PDIV;
         ST_LP_PDIV:  if (div_done) state_in = ST_LP_M3;
         ST_LP_M3:    if (mul_done) state_in = ST_FIN_DIV;
         ST_HP_MUL:   if (mul_done) state_in = ST_FIN_DIV;
         ST_AC_DIV:   if (supply_ff == 32'sd0 || div_done) state_in = ST_AC_M1;
         ST_AC_M1:    if (mul_done) state_in = ST_AC_M2;
         ST_AC_M2:    if (mul_done) state_in = ST_FIN_DIV;
         ST_FIN_DIV:  if (div_done) state_in = ST_LATCH;
         ST_LATCH:    if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // operand selection and datapath updates
   always_comb begin
      zero_sel  = req_chan.zero_ref_valid ? req_chan.zero_ref_code[15:4] : dzero_ff;
      full_sel  = req_chan.full_ref_valid ? req_chan.full_ref_code[15:4] : dfull_ff;
      v64       = 64'(volts_ff);
      d64       = 64'(diff_ff);
      s64       = 64'(aux_ff);
      span36    = 36'(span_ff);
      sat_div   = sat32(div_quo);
      sat_latch = sat32(v64 <<< 1);
      latch_hit = intbl_ff && board_ff == SUPPLY_BOARD && chan_ff == SUPPLY_CHAN;

      mul_start = 1'b0;
      mul_a     = v64;
      mul_b     = 33'(volts_ff);
      div_start = 1'b0;
      div_num   = x_ff;
      div_den   = fden_ff;

      op_busy_in   = op_busy_ff;
      board_in     = board_ff;
      chan_in      = chan_ff;
      diff_in      = diff_ff;
      span_in      = span_ff;
      intbl_in     = intbl_ff;
      sch_in       = sch_ff;
      flag_in      = flag_ff;
      volts_in     = volts_ff;
      aux_in       = aux_ff;
      phys_in      = phys_ff;
      x_in         = x_ff;
      fden_in      = fden_ff;
      supply_in    = supply_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      o_board_in   = o_board_ff;
      o_chan_in    = o_chan_ff;
      o_volts_in   = o_volts_ff;
      o_phys_in    = o_phys_ff;
      o_err_in     = o_err_ff;

      unique case (state_ff)
         // take the request, codes are the upper 12 bits
         ST_IDLE: begin
            if (accept) begin
               board_in   = req_chan.board_index;
               chan_in    = req_chan.channel_index;
               diff_in    = $signed({1'b0, req_chan.raw_code[15:4]}) - $signed({1'b0, zero_sel});
               span_in    = $signed({1'b0, full_sel}) - $signed({1'b0, zero_sel});
               intbl_in   = 32'(req_chan.board_index) < NUM_BOARDS
                            && 32'(req_chan.channel_index) < CHANNELS_PER_BOARD
                            && 32'(req_chan.board_index) < TBL_BOARDS
                            && 32'(req_chan.channel_index) < TBL_CHANS;
               sch_in     = scheme_of(req_chan.board_index, req_chan.channel_index);
               flag_in    = 1'b0;
               op_busy_in = 1'b0;
            end
         end
         // volts = 49 * diff * one / (10 * span)
         ST_VOLT: begin
            div_num = ((d64 <<< 5) + (d64 <<< 4) + d64) <<< FRAC_BITS;
            div_den = (span36 <<< 3) + (span36 <<< 1);
            if (span_ff == 13'sd0) begin
               volts_in = sign_max(d64);
               flag_in  = 1'b1;
            end else begin
               div_start = !op_busy_ff;
               if (!op_busy_ff) op_busy_in = 1'b1;
               if (div_done) begin
                  op_busy_in = 1'b0;
                  volts_in   = sat_div.val;
                  flag_in    = flag_ff | sat_div.ovf;
               end
            end
         end
         ST_DISPATCH: begin
            phys_in = volts_ff;
         end
         // linear: slope * v plus intercept (none on board 1), over 1e4
         ST_LIN_MUL: begin
            mul_b     = (board_ff == 2'd1) ? 33'(SLOPE_B1[chan_ff]) : LIN_SLOPE_STD;
            mul_start = !op_busy_ff;
            if (!op_busy_ff) op_busy_in = 1'b1;
            if (mul_done) begin
               op_busy_in = 1'b0;
               x_in       = mul_prod + ((board_ff == 2'd1) ? 64'sd0 : LIN_ICPT);
               fden_in    = DEN_E4;
            end
         end
         // low pressure: square of v
         ST_LP_SQ: begin
            mul_start = !op_busy_ff;
            if (!op_busy_ff) op_busy_in = 1'b1;
            if (mul_done) begin
               op_busy_in = 1'b0;
               x_in       = mul_prod;
            end
         end
         ST_LP_SQDIV: begin
            div_den   = DEN_W'(FX_ONE);
            div_start = !op_busy_ff;
            if (!op_busy_ff) op_busy_in = 1'b1;
            if (div_done) begin
               op_busy_in = 1'b0;
               aux_in     = sat_div.val;
               flag_in    = flag_ff | sat_div.ovf;
            end
         end
         ST_LP_M1: begin
            mul_a     = LP_C1;
            mul_start = !op_busy_ff;
            if (!op_busy_ff) op_busy_in = 1'b1;
            if (mul_done) begin
               op_busy_in = 1'b0;
               x_in       = mul_prod + LP_C0;
            end
         end
         ST_LP_M2: begin
            mul_a     = LP_C2;
            mul_b     = 33'(aux_ff);
            mul_start = !op_busy_ff;
            if (!op_busy_ff) op_busy_in = 1'b1;
            if (mul_done) begin
               op_busy_in = 1'b0;
               x_in       = x_ff - mul_prod;
            end
         end
         ST_LP_PDIV: begin
            div_den   = DEN_E4;
            div_start = !op_busy_ff;
            if (!op_busy_ff) op_busy_in = 1'b1;
            if (div_done) begin
               op_busy_in = 1'b0;
               x_in       = div_quo;
            end
         end
         ST_LP_M3: begin
            mul_a     = x_ff;
            mul_b     = LP_C3;
            mul_start = !op_busy_ff;
            if (!op_busy_ff) op_busy_in = 1'b1;
            if (mul_done) begin
               op_busy_in = 1'b0;
               x_in       = mul_prod;
               fden_in    = DEN_E10;
            end
         end
         // high pressure: (4v - one) * gain over 4e9
         ST_HP_MUL: begin
            mul_a     = (v64 <<< 2) - FX_ONE;
            mul_b     = HP_GAIN;
            mul_start = !op_busy_ff;
            if (!op_busy_ff) op_busy_in = 1'b1;
            if (mul_done) begin
               op_busy_in = 1'b0;
               x_in       = mul_prod;
               fden_in    = DEN_HP;
            end
         end
         // accelerometer: ratio of 5v against the latched supply
         ST_AC_DIV: begin
            div_num = ((v64 <<< 2) + v64) <<< FRAC_BITS;
            div_den = DEN_W'(supply_ff);
            if (supply_ff == 32'sd0) begin
               aux_in  = sign_max(v64);
               flag_in = 1'b1;
            end else begin
               div_start = !op_busy_ff;
               if (!op_busy_ff) op_busy_in = 1'b1;
               if (div_done) begin
                  op_busy_in = 1'b0;
                  aux_in     = sat_div.val;
                  flag_in    = flag_ff | sat_div.ovf;
               end
            end
         end
         ST_AC_M1: begin
            mul_a     = s64;
            mul_b     = MILLI;
            mul_start = !op_busy_ff;
            if (!op_busy_ff) op_busy_in = 1'b1;
            if (mul_done) begin
               op_busy_in = 1'b0;
               x_in       = mul_prod - (ACC_OFF[sch_ff] <<< FRAC_BITS);
            end
         end
         ST_AC_M2: begin
            mul_a     = x_ff;
            mul_b     = ACC_NUM[sch_ff];
            mul_start = !op_busy_ff;
            if (!op_busy_ff) op_busy_in = 1'b1;
            if (mul_done) begin
               op_busy_in = 1'b0;
               x_in       = mul_prod;
               fden_in    = ACC_DENK[sch_ff];
            end
         end
         // final rounding division shared by the linear, pressure and accelerometer schemes
         ST_FIN_DIV: begin
            div_start = !op_busy_ff;
            if (!op_busy_ff) op_busy_in = 1'b1;
            if (div_done) begin
               op_busy_in = 1'b0;
               phys_in    = sat_div.val;
               flag_in    = flag_ff | sat_div.ovf;
            end
         end
         // supply latch and hand-off to the output register
         ST_LATCH: begin
            if (out_free) begin
               if (latch_hit) supply_in = sat_latch.val;
               rsp_valid_in = 1'b1;
               o_board_in   = board_ff;
               o_chan_in    = chan_ff;
               o_volts_in   = volts_ff;
               o_phys_in    = phys_ff;
               o_err_in     = flag_ff | (latch_hit && sat_latch.ovf);
            end
         end
         default: begin
            op_busy_in = 1'b0;
         end
      endcase
   end

   // control and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_busy_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         supply_ff    <= 32'sd0;
         dzero_ff     <= DEFAULT_ZERO_RST;
         dfull_ff     <= DEFAULT_FULL_RST;
      end else begin
         state_ff     <= state_in;
         op_busy_ff   <= op_busy_in;
         rsp_valid_ff <= rsp_valid_in;
         supply_ff    <= supply_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_DEFAULT_ZERO: dzero_ff <= csr_wdata;
               CSR_DEFAULT_FULL: dfull_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      board_ff   <= board_in;
      chan_ff    <= chan_in;
      diff_ff    <= diff_in;
      span_ff    <= span_in;
      intbl_ff   <= intbl_in;
      sch_ff     <= sch_in;
      flag_ff    <= flag_in;
      volts_ff   <= volts_in;
      aux_ff     <= aux_in;
      phys_ff    <= phys_in;
      x_ff       <= x_in;
      fden_ff    <= fden_in;
      o_board_ff <= o_board_in;
      o_chan_ff  <= o_chan_in;
      o_volts_ff <= o_volts_in;
      o_phys_ff  <= o_phys_in;
      o_err_ff   <= o_err_in;
   end

   // result channel
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.out_board      = o_board_ff;
   assign rsp_chan.out_channel    = o_chan_ff;
   assign rsp_chan.volts_value    = o_volts_ff;
   assign rsp_chan.physical_value = o_phys_ff;
   assign rsp_chan.range_error    = o_err_ff;

endmodule
`default_nettype wire
